### hw/rtl/sliding_window_stats_defines.svh
// assertion macros used by sliding_window_stats.sv
`ifndef SLIDING_WINDOW_STATS_DEFINES_SVH
`define SLIDING_WINDOW_STATS_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication on clk, disabled in reset
`define SWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk, disabled in reset
`define SWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWS_ASSERT_IMP(lbl, ante, cons, msg)
`define SWS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/sws_pkg.sv
package sws_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 64;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = 7;
  localparam int SAMPLE_W     = 32;
  localparam int TOTAL_W      = 38;
  localparam int DIV_STEPS    = TOTAL_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int IN_DATA_W    = 40;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 176;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  // mode codes
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_DIV_SETUP,
    S_DIV,
    S_DIV_FIN,
    S_EMIT,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

  // ring position advance modulo the window depth
  function automatic logic [ADDR_W-1:0] pos_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(WINDOW_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // oldest held slot: (wp + depth - held) mod depth
  function automatic logic [ADDR_W-1:0] oldest_pos(input logic [ADDR_W-1:0] wp,
                                                   input logic [CNT_W-1:0] held);
    logic [CNT_W-1:0] t;
    t = CNT_W'(wp) + CNT_W'(WINDOW_DEPTH) - held;
    if (t >= CNT_W'(WINDOW_DEPTH)) t = t - CNT_W'(WINDOW_DEPTH);
    return t[ADDR_W-1:0];
  endfunction

endpackage

### hw/rtl/sws_ram.sv
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/sliding_window_stats.sv
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tuser mode, tdata sample, read_limit
// out_     out  out_tvalid/out_tready  tdata stats and element, tuser
//                                      element_valid, tlast last_of_run
//
// one item at a time; in_tready is high only while the sequencer is idle
// push: store, 38-step serial divide for the mean, emit;
//   a rescan of every held entry comes first after evicting the min or max
// clear and unused mode: status result only; read: an address and a data state per element (ram read)
// rst_n is synchronous active low and empties the window; no clearing pass
// a stalled out_tready holds the result register; the next item is still taken
`include "sliding_window_stats_defines.svh"

module sliding_window_stats (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] sample, [38:32] read_limit, [39] zero
  input  logic [sws_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  logic [sws_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] element, [38:32] fill_level, [70:39] window_minimum,
  // [102:71] window_maximum, [140:103] window_total, [172:141] window_mean,
  // [173] full_flag, [175:174] zero
  output logic [sws_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] element_valid
  output logic                            out_tuser,
  output logic                            out_tlast
);

  localparam int AW = sws_pkg::ADDR_W;
  localparam int CW = sws_pkg::CNT_W;
  localparam int SW = sws_pkg::SAMPLE_W;
  localparam int TW = sws_pkg::TOTAL_W;
  localparam int DW = sws_pkg::DIV_CNT_W;

  sws_pkg::state_t state_r, state_nxt;

  logic signed [SW-1:0] sample_r;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [CW-1:0]        held_r, held_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic signed [SW-1:0] min_r, min_nxt;
  logic signed [SW-1:0] max_r, max_nxt;
  logic signed [SW-1:0] mean_r, mean_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 scan_dv_r, scan_dv_nxt;
  logic [TW-1:0]        div_q_r, div_q_nxt;
  logic [CW-1:0]        div_rem_r, div_rem_nxt;
  logic [DW-1:0]        div_cnt_r, div_cnt_nxt;
  logic                 div_neg_r, div_neg_nxt;

  logic                    out_tvalid_r;
  logic [sws_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                    out_tuser_r, out_tlast_r;

  logic                 in_accept, out_free, out_load;
  logic signed [SW-1:0] out_elem;
  logic                 out_vbit, out_last;
  logic [sws_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic                 ram_wr_en, ram_rd_en;
  logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
  logic [SW-1:0]        ram_rd_data;
  logic signed [SW-1:0] rd_val;

  logic                 ring_full;
  logic signed [SW-1:0] evicted, new_min, new_max;
  logic [CW-1:0]        rd_limit, rd_n;
  logic [CW:0]          div_shift, div_trial;
  logic                 empty;

  assign in_tready = (state_r == sws_pkg::S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign rd_val    = $signed(ram_rd_data);
  assign empty     = (held_r == '0);

  // sample ring
  sws_ram #(
    .WIDTH(SW),
    .DEPTH(sws_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(sample_r),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // push arithmetic
  assign ring_full = (held_r == CW'(sws_pkg::WINDOW_DEPTH));
  assign evicted   = ring_full ? rd_val : '0;
  assign new_min   = (sample_r < min_r) ? sample_r : min_r;
  assign new_max   = (sample_r > max_r) ? sample_r : max_r;

  // read length clamp
  assign rd_limit = in_tdata[38:32];
  assign rd_n     = (rd_limit < held_r) ? rd_limit : held_r;

  // one restoring divide step
  assign div_shift = {div_rem_r, div_q_r[TW-1]};
  assign div_trial = div_shift - {1'b0, held_r};

  // result word from the statistics after the item
  assign out_data_nxt = {2'b00,
                         ring_full,
                         empty ? {SW{1'b0}} : mean_r,
                         empty ? {TW{1'b0}} : total_r,
                         empty ? {SW{1'b0}} : max_r,
                         empty ? {SW{1'b0}} : min_r,
                         held_r,
                         out_elem};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    held_nxt    = held_r;
    total_nxt   = total_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    mean_nxt    = mean_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    scan_dv_nxt = scan_dv_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_cnt_nxt = div_cnt_r;
    div_neg_nxt = div_neg_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wp_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = pos_r;
    out_load    = 1'b0;
    out_elem    = '0;
    out_vbit    = 1'b0;
    out_last    = 1'b1;

    unique case (state_r)
      sws_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_tuser)
            sws_pkg::MODE_PUSH: begin
              // fetch the sample about to be overwritten
              ram_rd_en   = ring_full;
              ram_rd_addr = wp_r;
              state_nxt   = sws_pkg::S_PUSH;
            end
            sws_pkg::MODE_CLEAR: begin
              wp_nxt    = '0;
              held_nxt  = '0;
              total_nxt = '0;
              min_nxt   = sws_pkg::SAMPLE_MAX;
              max_nxt   = sws_pkg::SAMPLE_MIN;
              mean_nxt  = '0;
              state_nxt = sws_pkg::S_EMIT;
            end
            sws_pkg::MODE_READ: begin
              cnt_nxt = rd_n;
              pos_nxt = sws_pkg::oldest_pos(wp_r, held_r);
              if (rd_n == '0) state_nxt = sws_pkg::S_EMIT;
              else state_nxt = sws_pkg::S_RD_ADDR;
            end
            default: begin
              state_nxt = sws_pkg::S_EMIT;
            end
          endcase
        end
      end

      sws_pkg::S_PUSH: begin
        // store sample, update total and extremes, or start a rescan after evicting one
        ram_wr_en = 1'b1;
        wp_nxt    = sws_pkg::pos_inc(wp_r);
        if (!ring_full) held_nxt = held_r + 1'b1;
        total_nxt = total_r + TW'(sample_r) - TW'(evicted);
        if (ring_full && (evicted == new_min || evicted == new_max)) begin
          min_nxt     = sws_pkg::SAMPLE_MAX;
          max_nxt     = sws_pkg::SAMPLE_MIN;
          pos_nxt     = sws_pkg::pos_inc(wp_r);
          cnt_nxt     = '0;
          scan_dv_nxt = 1'b0;
          state_nxt   = sws_pkg::S_SCAN;
        end else begin
          min_nxt   = new_min;
          max_nxt   = new_max;
          state_nxt = sws_pkg::S_DIV_SETUP;
        end
      end

      sws_pkg::S_SCAN: begin
        // fold in the entry read last cycle
        if (scan_dv_r) begin
          if (rd_val < min_r) min_nxt = rd_val;
          if (rd_val > max_r) max_nxt = rd_val;
        end
        if (cnt_r != held_r) begin
          ram_rd_en   = 1'b1;
          pos_nxt     = sws_pkg::pos_inc(pos_r);
          cnt_nxt     = cnt_r + 1'b1;
          scan_dv_nxt = 1'b1;
        end else begin
          scan_dv_nxt = 1'b0;
          if (!scan_dv_r) state_nxt = sws_pkg::S_DIV_SETUP;
        end
      end

      sws_pkg::S_DIV_SETUP: begin
        // divide the magnitude, fix the sign afterwards
        div_neg_nxt = total_r[TW-1];
        div_q_nxt   = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        state_nxt   = sws_pkg::S_DIV;
      end

      sws_pkg::S_DIV: begin
        if (!div_trial[CW]) begin
          div_rem_nxt = div_trial[CW-1:0];
          div_q_nxt   = {div_q_r[TW-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_shift[CW-1:0];
          div_q_nxt   = {div_q_r[TW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DW'(sws_pkg::DIV_STEPS - 1)) state_nxt = sws_pkg::S_DIV_FIN;
      end

      sws_pkg::S_DIV_FIN: begin
        mean_nxt  = div_neg_r ? -$signed(div_q_r[SW-1:0]) : $signed(div_q_r[SW-1:0]);
        state_nxt = sws_pkg::S_EMIT;
      end

      sws_pkg::S_EMIT: begin
        // single status result
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = sws_pkg::S_IDLE;
        end
      end

      sws_pkg::S_RD_ADDR: begin
        ram_rd_en = 1'b1;
        state_nxt = sws_pkg::S_RD_DATA;
      end

      sws_pkg::S_RD_DATA: begin
        // ram data holds until the result register frees up
        out_elem = rd_val;
        out_vbit = 1'b1;
        out_last = (cnt_r == CW'(1));
        if (out_free) begin
          out_load = 1'b1;
          pos_nxt  = sws_pkg::pos_inc(pos_r);
          cnt_nxt  = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) state_nxt = sws_pkg::S_IDLE;
          else state_nxt = sws_pkg::S_RD_ADDR;
        end
      end

      default: begin
        state_nxt = sws_pkg::S_IDLE;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sws_pkg::S_IDLE;
      wp_r         <= '0;
      held_r       <= '0;
      total_r      <= '0;
      min_r        <= sws_pkg::SAMPLE_MAX;
      max_r        <= sws_pkg::SAMPLE_MIN;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      held_r       <= held_nxt;
      total_r      <= total_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      out_tvalid_r <= out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= $signed(in_tdata[SW-1:0]);
    end
    mean_r    <= mean_nxt;
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    scan_dv_r <= scan_dv_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_neg_r <= div_neg_nxt;
    if (out_load) begin
      out_tdata_r <= out_data_nxt;
      out_tuser_r <= out_vbit;
      out_tlast_r <= out_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // checks
  `SWS_ASSERT_IMP(a_held_range, 1'b1, held_r <= CW'(sws_pkg::WINDOW_DEPTH), "held count over depth")
  `SWS_ASSERT_IMP(a_empty_origin, held_r == '0, wp_r == '0, "empty window with write position set")
  `SWS_ASSERT_IMP(a_load_free, out_load, !out_tvalid_r || out_tready, "result overwritten")
  `SWS_ASSERT_NXT(a_busy_after, in_accept, state_r != sws_pkg::S_IDLE, "idle right after accept")

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // mode code the block treats as a status-only no-op
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // [31:0] sample, [38:32] read_limit, [39] zero
  logic [sws_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  // [1:0] mode
  logic [sws_pkg::IN_USER_W-1:0]   in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [31:0] element, [38:32] fill_level, [70:39] window_minimum,
  // [102:71] window_maximum, [140:103] window_total, [172:141] window_mean,
  // [173] full_flag, [175:174] zero
  logic [sws_pkg::OUT_DATA_W-1:0]  out_tdata;
  // [0] element_valid
  logic                            out_tuser;
  logic                            out_tlast;

  sliding_window_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected result item
  typedef struct {
    logic [31:0] element;
    logic        elem_ok;
    logic [6:0]  fill;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [37:0] total;
    logic [31:0] mean;
    logic        full;
    logic        last;
  } window_result_t;

  // one row of the directed stimulus
  typedef struct {
    logic [1:0]  mode;
    logic [31:0] base;
    int          limit;
    int          reps;
    int          step;
    bit          typed;
    int          t_fill;
    logic [31:0] t_lo;
    logic [31:0] t_hi;
    logic [37:0] t_total;
    logic [31:0] t_mean;
  } stim_row_t;

  window_result_t stats_due[$];
  stim_row_t      stim_rows[$];

  // mirror of the window contents and statistics
  logic signed [31:0] ring_copy [sws_pkg::WINDOW_DEPTH];
  int                 wr_slot;
  int                 held;
  longint             run_sum;
  logic signed [31:0] win_lo;
  logic signed [31:0] win_hi;

  int pushes = 0;
  int rescans = 0;
  int reads = 0;
  int clears_other = 0;
  int items_taken = 0;
  int results_seen = 0;
  int failures = 0;

  function automatic void window_clear();
    wr_slot = 0;
    held    = 0;
    run_sum = 0;
    win_lo  = sws_pkg::SAMPLE_MAX;
    win_hi  = sws_pkg::SAMPLE_MIN;
  endfunction

  // statistics as reported after the current item
  function automatic window_result_t window_snapshot(logic [31:0] element, logic ok,
                                                     logic last);
    window_result_t r;
    longint         avg;
    r.element = element;
    r.elem_ok = ok;
    r.last    = last;
    r.fill    = 7'(held);
    r.full    = (held >= sws_pkg::WINDOW_DEPTH);
    if (held == 0) begin
      r.lo    = '0;
      r.hi    = '0;
      r.total = '0;
      r.mean  = '0;
    end else begin
      avg     = run_sum / longint'(held);
      r.lo    = win_lo;
      r.hi    = win_hi;
      r.total = 38'(run_sum);
      r.mean  = 32'(avg);
    end
    return r;
  endfunction

  // apply one accepted item to the mirror and queue what it must produce
  task automatic predict_window_stats(logic [1:0] mode, logic signed [31:0] smp, int limit);
    int                 n;
    int                 pos;
    bit                 at_depth;
    logic signed [31:0] gone;
    logic signed [31:0] v;
    n = 0;
    case (mode)
      sws_pkg::MODE_PUSH: begin
        pushes++;
        at_depth = (held >= sws_pkg::WINDOW_DEPTH);
        gone = '0;
        if (at_depth) begin
          gone = ring_copy[wr_slot];
          run_sum -= longint'(gone);
        end else begin
          held++;
        end
        ring_copy[wr_slot] = smp;
        wr_slot = (wr_slot + 1) % sws_pkg::WINDOW_DEPTH;
        run_sum += longint'(smp);
        if (smp < win_lo) win_lo = smp;
        if (smp > win_hi) win_hi = smp;
        // evicting the min or max forces a full rescan
        if (at_depth && (gone == win_lo || gone == win_hi)) begin
          rescans++;
          win_lo = sws_pkg::SAMPLE_MAX;
          win_hi = sws_pkg::SAMPLE_MIN;
          pos = (wr_slot + sws_pkg::WINDOW_DEPTH - held) % sws_pkg::WINDOW_DEPTH;
          for (int i = 0; i < held; i++) begin
            v = ring_copy[pos];
            if (v < win_lo) win_lo = v;
            if (v > win_hi) win_hi = v;
            pos = (pos + 1) % sws_pkg::WINDOW_DEPTH;
          end
        end
      end
      sws_pkg::MODE_CLEAR: begin
        clears_other++;
        window_clear();
      end
      sws_pkg::MODE_READ: begin
        reads++;
        n = (limit < held) ? limit : held;
        pos = (wr_slot + sws_pkg::WINDOW_DEPTH - held) % sws_pkg::WINDOW_DEPTH;
        for (int i = 0; i < n; i++) begin
          stats_due.push_back(window_snapshot(ring_copy[pos], 1'b1, i == n - 1));
          pos = (pos + 1) % sws_pkg::WINDOW_DEPTH;
        end
      end
      default: clears_other++;
    endcase
    // status-only result for everything that emits no element
    if (n == 0) stats_due.push_back(window_snapshot('0, 1'b0, 1'b1));
  endtask

  // offer one item and wait for the handshake
  task automatic offer_item(logic [1:0] mode, logic [31:0] smp, int limit);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, 7'(limit), smp};
    do @(posedge clk); while (!in_tready);
    items_taken++;
    predict_window_stats(mode, smp, limit);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic void add_row(logic [1:0] mode, logic [31:0] base, int limit,
                                  int reps = 1, int step = 0, bit typed = 1'b0,
                                  int t_fill = 0, logic [31:0] t_lo = '0,
                                  logic [31:0] t_hi = '0, logic [37:0] t_total = '0,
                                  logic [31:0] t_mean = '0);
    stim_row_t r;
    r.mode = mode;   r.base = base;     r.limit = limit; r.reps = reps;
    r.step = step;   r.typed = typed;   r.t_fill = t_fill;
    r.t_lo = t_lo;   r.t_hi = t_hi;     r.t_total = t_total;
    r.t_mean = t_mean;
    stim_rows.push_back(r);
  endfunction

  // mix of small values (for repeated min/max), extremes, q16.16 and raw bits
  function automatic logic [31:0] random_sample();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 8) return 32'(int'($urandom_range(0, 15)) - 8);
    if (kind < 11) begin
      case ($urandom_range(0, 3))
        0: return sws_pkg::SAMPLE_MAX;
        1: return sws_pkg::SAMPLE_MIN;
        2: return 32'h0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (kind < 15) return 32'((int'($urandom_range(0, 400)) - 200) * 65536);
    return $urandom;
  endfunction

  function automatic int random_limit();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom_range(0, 64);
    if (kind < 7) return $urandom_range(0, 8);
    if (kind < 9) return 64;
    return 0;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("result %0d %s: expected %h actual %h", results_seen, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with none expected: tdata %h", results_seen,
                   out_tdata);
      end else begin
        want = stats_due.pop_front();
        compare_field("element", want.element, out_tdata[31:0]);
        compare_field("fill_level", want.fill, out_tdata[38:32]);
        compare_field("window_minimum", want.lo, out_tdata[70:39]);
        compare_field("window_maximum", want.hi, out_tdata[102:71]);
        compare_field("window_total", want.total, out_tdata[140:103]);
        compare_field("window_mean", want.mean, out_tdata[172:141]);
        compare_field("full_flag", want.full, out_tdata[173]);
        compare_field("element_valid", want.elem_ok, out_tuser);
        compare_field("last_of_run", want.last, out_tlast);
      end
    end
  end

  // receiver readiness: changing patterns plus one long hold-off
  initial begin : drain_pattern
    int style;
    int len;
    bit held_off;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      if (!held_off && items_taken >= 320) begin
        held_off = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      style = $urandom_range(0, 3);
      len = $urandom_range(10, 150);
      for (int c = 0; c < len; c++) begin
        @(negedge clk);
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ((c % 4) != 3);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [1:0] mode;
    int         pick;
    int         burst_left;
    burst_left = 0;
    window_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty window, spare code and the sample extremes
    add_row(sws_pkg::MODE_READ, 32'h0, 64, 1, 0, 1'b1, 0, '0, '0, '0, '0);
    add_row(sws_pkg::MODE_CLEAR, 32'h0, 0, 1, 0, 1'b1, 0, '0, '0, '0, '0);
    add_row(MODE_SPARE, 32'hDEAD_BEEF, 64, 1, 0, 1'b1, 0, '0, '0, '0, '0);
    add_row(sws_pkg::MODE_PUSH, sws_pkg::SAMPLE_MAX, 0, 1, 0, 1'b1, 1,
            sws_pkg::SAMPLE_MAX, sws_pkg::SAMPLE_MAX, 38'h00_7FFF_FFFF,
            sws_pkg::SAMPLE_MAX);
    add_row(sws_pkg::MODE_PUSH, sws_pkg::SAMPLE_MIN, 0, 1, 0, 1'b1, 2,
            sws_pkg::SAMPLE_MIN, sws_pkg::SAMPLE_MAX, 38'h3F_FFFF_FFFF, 32'h0);
    // read with zero limit, one element, and a limit past the fill level
    add_row(sws_pkg::MODE_READ, 32'h0, 0);
    add_row(sws_pkg::MODE_READ, 32'h0, 1);
    add_row(sws_pkg::MODE_READ, 32'h0, 64);
    add_row(MODE_SPARE, 32'h1234_5678, 3);
    add_row(sws_pkg::MODE_CLEAR, 32'h0, 0, 1, 0, 1'b1, 0, '0, '0, '0, '0);
    // negative mean truncation, then fill to full and evict the minimum
    add_row(sws_pkg::MODE_PUSH, 32'hFFFF_FFFD, 0);
    add_row(sws_pkg::MODE_PUSH, 32'h0, 0);
    add_row(sws_pkg::MODE_PUSH, 32'hFFFF_FC18, 0, 62, 37);
    add_row(sws_pkg::MODE_PUSH, 32'h5, 0);
    add_row(sws_pkg::MODE_PUSH, 32'h0001_0000, 0, 8, -65536);
    add_row(sws_pkg::MODE_READ, 32'h0, 64);
    add_row(sws_pkg::MODE_READ, 32'h0, 63);
    // full window of the largest, then the smallest sample
    add_row(sws_pkg::MODE_PUSH, sws_pkg::SAMPLE_MAX, 0, 64);
    add_row(sws_pkg::MODE_PUSH, sws_pkg::SAMPLE_MIN, 0, 64);
    add_row(sws_pkg::MODE_READ, 32'h0, 64);
    add_row(sws_pkg::MODE_CLEAR, 32'h0, 0);
    add_row(sws_pkg::MODE_READ, 32'h0, 5);

    foreach (stim_rows[k]) begin
      for (int j = 0; j < stim_rows[k].reps; j++) begin
        offer_item(stim_rows[k].mode, 32'(stim_rows[k].base + j * stim_rows[k].step),
                   stim_rows[k].limit);
        if (stim_rows[k].typed) begin
          stats_due[$].fill  = 7'(stim_rows[k].t_fill);
          stats_due[$].lo    = stim_rows[k].t_lo;
          stats_due[$].hi    = stim_rows[k].t_hi;
          stats_due[$].total = stim_rows[k].t_total;
          stats_due[$].mean  = stim_rows[k].t_mean;
        end
      end
    end

    // random traffic in bursts; clears are rare so the window fills and wraps
    for (int k = 0; k < 214; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 20));
      end
      burst_left--;
      pick = $urandom_range(0, 199);
      if (pick < 2) mode = sws_pkg::MODE_CLEAR;
      else if (pick < 6) mode = MODE_SPARE;
      else if (pick < 56) mode = sws_pkg::MODE_READ;
      else mode = sws_pkg::MODE_PUSH;
      offer_item(mode, random_sample(), random_limit());
    end
    pause_input(1);

    // drain, then watch for stray results
    while (stats_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d items: %0d pushes (%0d min/max rescans), %0d reads,",
             items_taken, pushes, rescans, reads);
    $display("%0d clears or spare codes; %0d results checked, %0d failures",
             clears_other, results_seen, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("timeout with %0d results still due", stats_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
